/* rtl/core/stq_pkg.sv */
// shared types and constants for the sorted timer queue
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;
  localparam int QueueDepth = 16;
  localparam int CntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  handler_kind;
    logic [31:0] dest_address;
    logic [31:0] deadline_sec;
    logic [19:0] deadline_usec;
  } stq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  head_handler;
    logic [31:0] head_address;
    logic [31:0] head_sec;
    logic [19:0] head_usec;
    logic [4:0]  entry_count;
  } stq_out_t;

  typedef struct packed {
    logic [3:0]  handler;
    logic [31:0] address;
    logic [31:0] sec;
    logic [19:0] usec;
  } stq_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic remove;   // delete matched entry
    logic insert;   // insert request entry
    logic result;   // build result
  } stq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic full_after;
  } stq_stat_t;
endpackage
`default_nettype wire

/* rtl/core/stq_ctrl.sv */
// controller state machine for the sorted timer queue
`timescale 1ns / 1ps
`default_nettype none
module stq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire stq_pkg::stq_stat_t stat,
  output stq_pkg::stq_cmd_t     cmd
);
  import stq_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.remove = 1'b1;
        cmd.insert = 1'b1;
        cmd.result = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a request is only taken from idle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.result) else $error("load not followed by execute");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |=> !cmd.result) else $error("execute twice");
  // a removal always frees a cell
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> !(stat.found && stat.full_after)) else $error("full after removal");
endmodule
`default_nettype wire

/* rtl/core/stq_dp.sv */
// datapath: sorted cell row with match, delete and insert
`timescale 1ns / 1ps
`default_nettype none
module stq_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stq_pkg::stq_in_t   in_data,
  input  wire logic [3:0]         key_handler,
  input  wire stq_pkg::stq_cmd_t  cmd,
  output stq_pkg::stq_stat_t      stat,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output stq_pkg::stq_out_t       out_data
);
  import stq_pkg::*;

  stq_entry_t           ent_r [QueueDepth];
  logic [CntW-1:0]      cnt_r;
  stq_in_t              req_r;
  logic [QueueDepth-1:0] hit_r;
  logic                 out_valid_r;
  stq_out_t             out_r;
  stq_out_t             out_nxt;

  // per-cell match against the incoming request, registered
  logic [QueueDepth-1:0] hit_c;
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (in_data.handler_kind == key_handler) begin
        hit_c[i] = ent_r[i].handler == key_handler;
      end else begin
        hit_c[i] = ent_r[i].handler == in_data.handler_kind &&
                   ent_r[i].address == in_data.dest_address;
      end
      hit_c[i] = hit_c[i] && (CntW'(i) < cnt_r);
    end
  end

  // first hit one-hot and cells at or after it
  logic [QueueDepth-1:0] first_hit, after_hit;
  always_comb begin
    first_hit = hit_r & (~hit_r + QueueDepth'(1));
    after_hit = ~(first_hit - QueueDepth'(1)) & {QueueDepth{|hit_r}};
  end

  // compacted view after removal
  stq_entry_t      cmp_e [QueueDepth];
  logic [CntW-1:0] cnt_c;
  logic            found;
  always_comb begin
    found = |hit_r && (req_r.opcode == OP_ADD || req_r.opcode == OP_REMOVE);
    for (int i = 0; i < QueueDepth - 1; i++) begin
      if (found && after_hit[i]) cmp_e[i] = ent_r[i + 1];
      else cmp_e[i] = ent_r[i];
    end
    cmp_e[QueueDepth - 1] = ent_r[QueueDepth - 1];
    cnt_c = found ? cnt_r - CntW'(1) : cnt_r;
  end

  // insert: cells earlier than new deadline stay, rest shift up
  stq_entry_t            new_e;
  logic [QueueDepth-1:0] early;
  logic                  full_c;
  always_comb begin
    new_e = '{req_r.handler_kind, req_r.dest_address,
              req_r.deadline_sec, req_r.deadline_usec};
    for (int i = 0; i < QueueDepth; i++) begin
      early[i] = (CntW'(i) < cnt_c) &&
                 (cmp_e[i].sec < req_r.deadline_sec ||
                  (cmp_e[i].sec == req_r.deadline_sec &&
                   cmp_e[i].usec < req_r.deadline_usec));
    end
    full_c = cnt_c == CntW'(QueueDepth);
  end

  assign stat.found = found;
  assign stat.full_after = full_c;

  // result for the current request
  always_comb begin
    out_nxt = '0;
    out_nxt.entry_count = 5'(cnt_c);
    case (req_r.opcode)
      OP_ADD: begin
        if (full_c) out_nxt.status = ST_FULL;
        else out_nxt.entry_count = 5'(cnt_c + CntW'(1));
      end
      OP_REMOVE: if (!found) out_nxt.status = ST_NOT_FOUND;
      OP_PEEK: begin
        if (cnt_r == '0) out_nxt.status = ST_EMPTY;
        else begin
          out_nxt.head_handler = ent_r[0].handler;
          out_nxt.head_address = ent_r[0].address;
          out_nxt.head_sec = ent_r[0].sec;
          out_nxt.head_usec = ent_r[0].usec;
        end
      end
      default: ;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      hit_r <= hit_c;
    end
    if (cmd.insert && req_r.opcode == OP_ADD && !full_c) begin
      ent_r[0] <= early[0] ? cmp_e[0] : new_e;
      for (int i = 1; i < QueueDepth; i++) begin
        if (early[i]) ent_r[i] <= cmp_e[i];
        else if (early[i - 1]) ent_r[i] <= new_e;
        else ent_r[i] <= cmp_e[i - 1];
      end
    end else if (cmd.remove) begin
      for (int i = 0; i < QueueDepth; i++) begin
        ent_r[i] <= cmp_e[i];
      end
    end
    if (cmd.result) out_r <= out_nxt;
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.insert && req_r.opcode == OP_ADD && !full_c) cnt_r <= cnt_c + CntW'(1);
      else if (cmd.remove) cnt_r <= cnt_c;
      if (cmd.result) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(QueueDepth)) else $error("count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove && req_r.opcode == OP_PEEK |=> $stable(cnt_r))
    else $error("peek changed count");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> $onehot0(first_hit)) else $error("first hit not one-hot");
endmodule
`default_nettype wire

/* rtl/core/sorted_timer_queue.sv */
// top level of the sorted timer queue
// a request is captured in idle and its result is registered in the execute state that follows
// a new request is taken only in idle, not while one executes; the cell row updates once per request
// the next request is taken while a result waits only when that result is taken
// reset: synchronous active low; queue empty, key handler 0, no result pending
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire stq_pkg::stq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output stq_pkg::stq_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_wdata
);
  import stq_pkg::*;

  logic [3:0] key_r;
  stq_cmd_t   cmd;
  stq_stat_t  stat;

  // key request handler register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_wdata;
    end
  end

  stq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  stq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .key_handler(key_r),
    .cmd(cmd), .stat(stat), .out_ready(out_ready), .out_valid(out_valid),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the sorted timer queue
`timescale 1ns / 1ps
module testbench;
  import stq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  stq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  stq_out_t out_data;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  // idle percentages for sender and receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  stq_out_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  // shadow queue state
  stq_entry_t shadow_entries[QueueDepth];
  int shadow_count = 0;
  logic [3:0] shadow_key_handler = '0;

  sorted_timer_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // locate first timer matching handler/address rules
  function automatic int find_timer(logic [3:0] hnd, logic [31:0] addr);
    for (int i = 0; i < shadow_count; i++) begin
      if (hnd == shadow_key_handler) begin
        if (shadow_entries[i].handler == shadow_key_handler) return i;
      end else if (shadow_entries[i].handler == hnd && shadow_entries[i].address == addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_count--;
  endfunction

  // apply one request to the shadow queue and return its result
  function automatic stq_out_t apply_timer_op(stq_in_t req);
    stq_out_t res;
    int m;
    int pos;
    res = '0;
    res.status = ST_OK;
    case (req.opcode)
      OP_ADD: begin
        m = find_timer(req.handler_kind, req.dest_address);
        if (m >= 0) drop_timer(m);
        if (shadow_count >= QueueDepth) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count &&
                 (shadow_entries[pos].sec < req.deadline_sec ||
                  (shadow_entries[pos].sec == req.deadline_sec &&
                   shadow_entries[pos].usec < req.deadline_usec)))
            pos++;
          for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos] = '{req.handler_kind, req.dest_address,
                                  req.deadline_sec, req.deadline_usec};
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        m = find_timer(req.handler_kind, req.dest_address);
        if (m >= 0) drop_timer(m);
        else res.status = ST_NOT_FOUND;
      end
      OP_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.head_handler = shadow_entries[0].handler;
          res.head_address = shadow_entries[0].address;
          res.head_sec = shadow_entries[0].sec;
          res.head_usec = shadow_entries[0].usec;
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(shadow_count);
    return res;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    stq_out_t exp_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          mismatch_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.status != out_data.status)
            $display("%0t: status exp %0d got %0d", $time, exp_res.status, out_data.status);
          if (exp_res.head_handler != out_data.head_handler)
            $display("%0t: head_handler exp %0d got %0d", $time,
                     exp_res.head_handler, out_data.head_handler);
          if (exp_res.head_address != out_data.head_address)
            $display("%0t: head_address exp %h got %h", $time,
                     exp_res.head_address, out_data.head_address);
          if (exp_res.head_sec != out_data.head_sec)
            $display("%0t: head_sec exp %h got %h", $time, exp_res.head_sec, out_data.head_sec);
          if (exp_res.head_usec != out_data.head_usec)
            $display("%0t: head_usec exp %h got %h", $time, exp_res.head_usec, out_data.head_usec);
          if (exp_res.entry_count != out_data.entry_count)
            $display("%0t: entry_count exp %0d got %0d", $time,
                     exp_res.entry_count, out_data.entry_count);
          if (exp_res !== out_data) mismatch_count++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // send one request, with optional random idle first; valid stays up
  // after acceptance until the next idle cycle or drain
  task automatic send_request(stq_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(apply_timer_op(req));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key_handler(logic [3:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_key_handler = value;
  endtask

  function automatic stq_in_t make_request(logic [1:0] op, logic [3:0] hnd, logic [31:0] addr,
                                           logic [31:0] sec, logic [19:0] usec);
    stq_in_t r;
    r.opcode = op;
    r.handler_kind = hnd;
    r.dest_address = addr;
    r.deadline_sec = sec;
    r.deadline_usec = usec;
    return r;
  endfunction

  // directed extremes, ties, full queue, empty peek, unused opcode
  task automatic test_directed();
    send_request(make_request(OP_PEEK, 4'd0, '0, '0, '0));
    send_request(make_request(OP_REMOVE, 4'd3, 32'h1, '0, '0));
    send_request(make_request(OP_ADD, 4'hf, '1, '1, 20'hfffff));
    send_request(make_request(OP_ADD, 4'd1, 32'h10, 32'd5, 20'd7));
    send_request(make_request(OP_ADD, 4'd2, 32'h20, 32'd5, 20'd7));
    send_request(make_request(OP_ADD, 4'd0, '0, '0, '0));
    send_request(make_request(OP_PEEK, 4'd0, '0, '0, '0));
    send_request(make_request(OP_ADD, 4'd0, 32'h55, 32'd9, 20'd999999));
    send_request(make_request(OP_ADD, 4'd1, 32'h10, 32'd4, 20'd1));
    send_request(make_request(2'd3, 4'd9, 32'h9, 32'd9, 20'd9));
    send_request(make_request(OP_REMOVE, 4'd1, 32'h10, '0, '0));
    for (int i = 0; i < 14; i++)
      send_request(make_request(OP_ADD, 4'(i % 15 + 1), 32'(i + 100), 32'd3, 20'(i)));
    send_request(make_request(OP_ADD, 4'd7, 32'hdead, '0, 20'd1));
    send_request(make_request(OP_PEEK, 4'd0, '0, '0, '0));
  endtask

  function automatic stq_in_t random_request();
    stq_in_t r;
    int pick;
    r = make_request(2'($urandom_range(2)), 4'($urandom_range(15)),
                     32'($urandom_range(3)), 32'($urandom_range(3)), 20'($urandom_range(3)));
    pick = $urandom_range(99);
    if (pick < 2) r.opcode = 2'd3;
    if (pick >= 90) begin
      r.dest_address = $urandom();
      r.deadline_sec = $urandom();
      r.deadline_usec = 20'($urandom());
    end
    // drain the queue sometimes by favoring removes
    if (shadow_count > 12 && $urandom_range(1)) r.opcode = OP_REMOVE;
    if (r.opcode == OP_REMOVE && shadow_count > 0 && $urandom_range(3) != 0) begin
      pick = $urandom_range(shadow_count - 1);
      r.handler_kind = shadow_entries[pick].handler;
      r.dest_address = shadow_entries[pick].address;
    end
    return r;
  endfunction

  task automatic test_random_phase(int unsigned count, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  task automatic test_random();
    logic [3:0] key_values[4] = '{4'd0, 4'd15, 4'd6, 4'd0};
    for (int k = 0; k < 4; k++) begin
      write_key_handler(key_values[k]);
      test_random_phase(200, 0, 0);
      test_random_phase(60, 85, 0);
      test_random_phase(60, 0, 85);
      test_random_phase(80, 7, 7);
      // hold off until the queue has answered everything
      wait_drained();
      test_random_phase(0, 0, 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_key_handler(4'd15);
    test_directed();
    test_random();
    recv_stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d requests and %0d results over four key handler settings",
             requests_sent, results_seen);
    $display("idle phases: none, sender heavy, receiver heavy, light mixed");
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/stq_pkg.sv
rtl/core/stq_ctrl.sv
rtl/core/stq_dp.sv
rtl/core/sorted_timer_queue.sv
sim/testbench.sv
